// ===== rtl/cordic_rotate_vector_defines.svh =====
`ifndef CORDIC_ROTATE_VECTOR_DEFINES_SVH
`define CORDIC_ROTATE_VECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crv_pkg.sv =====
package crv_pkg;

  localparam int ITERATIONS  = 12;
  localparam int TABLE_LEN   = 14;
  localparam int IDXW        = $clog2(TABLE_LEN);
  localparam int XW          = 17;
  localparam int ZW          = 16;
  localparam int GW          = 15;
  localparam int PW          = XW + GW;
  localparam int HALF_PI_311 = 3216;
  localparam int GAIN_COMP   = 9949;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_POS,
    DIR_NEG
  } dir_e;

  typedef struct packed {
    logic                 vec;
    dir_e                 dir;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } crv_data_t;

  // arctangent of 2^-i in Q2.12
  function automatic logic [11:0] atan_f(logic [IDXW-1:0] i);
    logic [11:0] r;
    unique case (i)
      IDXW'(0):  r = 12'hC90;
      IDXW'(1):  r = 12'h76B;
      IDXW'(2):  r = 12'h3EB;
      IDXW'(3):  r = 12'h1FD;
      IDXW'(4):  r = 12'h0FF;
      IDXW'(5):  r = 12'h07F;
      IDXW'(6):  r = 12'h03F;
      IDXW'(7):  r = 12'h01F;
      IDXW'(8):  r = 12'h00F;
      IDXW'(9):  r = 12'h007;
      IDXW'(10): r = 12'h003;
      IDXW'(11): r = 12'h001;
      default:   r = 12'h000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/crv_fold.sv =====
module crv_fold import crv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic              req_type_i,
  input  logic signed [11:0] magnitude_or_x_i,
  input  logic signed [11:0] angle_or_y_i,
  output logic              valid_o,
  input  logic              ready_i,
  output crv_data_t         data_o
);

  localparam logic signed [ZW-1:0] HalfPiZ = ZW'(HALF_PI_311);

  logic      valid_q;
  crv_data_t data_q, data_d;
  logic signed [XW-1:0] ax, bx;
  logic signed [ZW-1:0] zr;

  always_comb begin
    ax = XW'(magnitude_or_x_i) <<< 2;
    bx = XW'(angle_or_y_i) <<< 2;
    zr = ZW'(angle_or_y_i) <<< 2;
    data_d.vec = req_type_i;
    data_d.dir = DIR_NONE;
    data_d.x   = ax;
    data_d.y   = '0;
    data_d.z   = '0;
    if (!req_type_i) begin
      if (zr >= HalfPiZ) begin
        zr = zr - HalfPiZ;
        data_d.dir = DIR_POS;
      end else if (zr <= -HalfPiZ) begin
        zr = zr + HalfPiZ;
        data_d.dir = DIR_NEG;
      end
      data_d.z = zr <<< 1;
    end else begin
      data_d.y = bx;
      // left half plane: quarter turn into the right half
      if (ax <= 0) begin
        if (bx <= 0) begin
          data_d.x   = -bx;
          data_d.y   = ax;
          data_d.dir = DIR_POS;
        end else begin
          data_d.x   = bx;
          data_d.y   = -ax;
          data_d.dir = DIR_NEG;
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/crv_cell.sv =====
module crv_cell import crv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IDXW-1:0] idx_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  crv_data_t       data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output crv_data_t       data_o
);

  logic      valid_q;
  crv_data_t data_q, data_d;
  logic      pos;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;

  always_comb begin
    pos    = data_i.vec ? (data_i.y < 0) : (data_i.z >= 0);
    dx     = data_i.y >>> idx_i;
    dy     = data_i.x >>> idx_i;
    ang    = $signed(ZW'(atan_f(idx_i)));
    data_d = data_i;
    if (pos) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ang;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ang;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/crv_gain.sv =====
module crv_gain import crv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  crv_data_t         data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [12:0] x_or_magnitude_o,
  output logic signed [11:0] y_or_angle_o
);

  localparam int SW = PW - 14 + 1;
  localparam logic signed [GW-1:0] GainS  = GW'(GAIN_COMP);
  localparam logic signed [SW-1:0] HalfPiS = SW'(HALF_PI_311);

  function automatic logic signed [12:0] sat13(logic signed [SW-1:0] v);
    logic signed [12:0] r;
    if (v > SW'(4095)) r = 13'sd4095;
    else if (v < -SW'(4096)) r = -13'sd4096;
    else r = v[12:0];
    return r;
  endfunction

  function automatic logic signed [11:0] sat12(logic signed [SW-1:0] v);
    logic signed [11:0] r;
    if (v > SW'(2047)) r = 12'sd2047;
    else if (v < -SW'(2048)) r = -12'sd2048;
    else r = v[11:0];
    return r;
  endfunction

  // multiply stage
  logic                 mv_q;
  logic                 vec_q;
  dir_e                 dir_q;
  logic signed [PW-1:0] px_q, py_q, px_d, py_d;
  logic signed [ZW-1:0] z_q;
  // output stage
  logic                 ov_q;
  logic signed [12:0]   o0_q, o0_d;
  logic signed [11:0]   o1_q, o1_d;
  logic                 rdy2;
  logic signed [SW-1:0] xs, ys, xr, yr, zh, zt;

  assign px_d = data_i.x * GainS;
  assign py_d = data_i.y * GainS;

  always_comb begin
    xs = SW'(px_q >>> 14);
    ys = SW'(py_q >>> 14);
    zh = SW'(z_q) >>> 1;
    xr = xs;
    yr = ys;
    zt = zh;
    case (dir_q)
      DIR_POS: begin
        xr = -ys;
        yr = xs;
        zt = zh - HalfPiS;
      end
      DIR_NEG: begin
        xr = ys;
        yr = -xs;
        zt = zh + HalfPiS;
      end
      default: ;
    endcase
    if (vec_q) begin
      o0_d = sat13(xs >>> 2);
      o1_d = sat12(zt >>> 2);
    end else begin
      o0_d = sat13(xr >>> 2);
      o1_d = sat12(yr >>> 2);
    end
  end

  assign rdy2    = !ov_q || !out_stall_i;
  assign ready_o = !mv_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mv_q <= valid_i;
      end
      if (rdy2) begin
        ov_q <= mv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      z_q   <= data_i.z;
      vec_q <= data_i.vec;
      dir_q <= data_i.dir;
    end
    if (rdy2 && mv_q) begin
      o0_q <= o0_d;
      o1_q <= o1_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign x_or_magnitude_o = o0_q;
  assign y_or_angle_o     = o1_q;

endmodule

// ===== rtl/cordic_rotate_vector.sv =====
// circular cordic, rotation (polar to rect) and vectoring (rect to polar)
// input channel: in_valid_i / in_stall_o carrying req_type_i,
//   magnitude_or_x_i and angle_or_y_i; an item is taken when valid is high
//   and stall is low
// output channel: out_valid_o / out_stall_i carrying x_or_magnitude_o and
//   y_or_angle_o, one result item for every input item, in order
// the item passes a fold stage, one cell per micro-rotation (12 cells) and
//   a two-stage gain and output section, each stage registered, before it
//   reaches out_valid_o
// throughput is one item per clock when the output is not stalled; every stage
//   holds its own valid bit so bubbles close up and new items enter while a result waits at the output
// a stalled output holds its item; stages behind it keep filling until the
//   chain is full, then in_stall_o rises
// reset clears every valid bit, so the pipeline comes up empty and ready
`include "cordic_rotate_vector_defines.svh"
module cordic_rotate_vector import crv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic signed [11:0] magnitude_or_x_i,
  input  logic signed [11:0] angle_or_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [12:0] x_or_magnitude_o,
  output logic signed [11:0] y_or_angle_o
);

  logic      vld   [ITERATIONS+1];
  logic      rdy   [ITERATIONS+2];
  crv_data_t dat   [ITERATIONS+1];

  crv_fold u_fold (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .ready_o         (rdy[0]),
    .req_type_i      (req_type_i),
    .magnitude_or_x_i(magnitude_or_x_i),
    .angle_or_y_i    (angle_or_y_i),
    .valid_o         (vld[0]),
    .ready_i         (rdy[1]),
    .data_o          (dat[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    crv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDXW'(k)),
      .valid_i(vld[k]),
      .ready_o(rdy[k+1]),
      .data_i (dat[k]),
      .valid_o(vld[k+1]),
      .ready_i(rdy[k+2]),
      .data_o (dat[k+1])
    );
  end

  crv_gain u_gain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (vld[ITERATIONS]),
    .ready_o         (rdy[ITERATIONS+1]),
    .data_i          (dat[ITERATIONS]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .x_or_magnitude_o(x_or_magnitude_o),
    .y_or_angle_o    (y_or_angle_o)
  );

  assign in_stall_o = !rdy[0];

  `CRV_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, vld[0],
    "accepted item did not reach the fold stage")
  `CRV_ASSERT_NOW(a_free_output_free_input, !out_stall_i, !in_stall_o,
    "input stalled although the output is free")
  `CRV_ASSERT_NEXT(a_last_cell_holds, vld[ITERATIONS] && !rdy[ITERATIONS+1],
    vld[ITERATIONS], "last cell dropped an item while the gain stage was full")

endmodule

// ===== tb/cordic_rotate_vector_tb.sv =====
module cordic_rotate_vector_tb import crv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [12:0] x_or_mag;
    logic signed [11:0] y_or_ang;
  } cordic_out_t;

  localparam int ARCTAN_Q212 [14] = '{
    32'h0C90, 32'h076B, 32'h03EB, 32'h01FD, 32'h00FF, 32'h007F, 32'h003F,
    32'h001F, 32'h000F, 32'h0007, 32'h0003, 32'h0001, 32'h0000, 32'h0000
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              req_type_i = 1'b0;
  logic signed [11:0] magnitude_or_x_i = '0;
  logic signed [11:0] angle_or_y_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [12:0] x_or_magnitude_o;
  logic signed [11:0] y_or_angle_o;

  cordic_out_t converted_q [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  cordic_rotate_vector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .magnitude_or_x_i (magnitude_or_x_i),
    .angle_or_y_i     (angle_or_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .x_or_magnitude_o (x_or_magnitude_o),
    .y_or_angle_o     (y_or_angle_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // polar <-> rect conversion, bit exact with the pipeline
  function automatic cordic_out_t cordic_convert(logic vec, logic signed [11:0] a,
                                                 logic signed [11:0] b);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint t;
    dir_e turn;
    int i;
    cordic_out_t r;
    turn = DIR_NONE;
    if (!vec) begin
      x = 4 * longint'(a);
      y = 0;
      z = 4 * longint'(b);
      if (z >= HALF_PI_311) begin
        z -= HALF_PI_311;
        turn = DIR_POS;
      end else if (z <= -HALF_PI_311) begin
        z += HALF_PI_311;
        turn = DIR_NEG;
      end
      z *= 2;
    end else begin
      x = 4 * longint'(a);
      y = 4 * longint'(b);
      z = 0;
      // fold the left half plane into the right one
      if (x <= 0) begin
        t = x;
        if (y <= 0) begin
          x = -y;
          y = t;
          turn = DIR_POS;
        end else begin
          x = y;
          y = -t;
          turn = DIR_NEG;
        end
      end
    end
    for (i = 0; i < ITERATIONS && i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (vec ? (y < 0) : (z >= 0)) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q212[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q212[i];
      end
    end
    if (!vec) begin
      x = (x * GAIN_COMP) >>> 14;
      y = (y * GAIN_COMP) >>> 14;
      t = x;
      if (turn == DIR_POS) begin
        x = -y;
        y = t;
      end else if (turn == DIR_NEG) begin
        x = y;
        y = -t;
      end
      r.x_or_mag = 13'(clamp(x >>> 2, 13));
      r.y_or_ang = 12'(clamp(y >>> 2, 12));
    end else begin
      z = z >>> 1;
      x = (x * GAIN_COMP) >>> 14;
      if (turn == DIR_POS) z -= HALF_PI_311;
      else if (turn == DIR_NEG) z += HALF_PI_311;
      r.x_or_mag = 13'(clamp(x >>> 2, 13));
      r.y_or_ang = 12'(clamp(z >>> 2, 12));
    end
    return r;
  endfunction

  // valid is left high after acceptance so back-to-back items need no glitch
  task automatic send_item(logic vec, logic signed [11:0] a, logic signed [11:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= vec;
    magnitude_or_x_i <= a;
    angle_or_y_i     <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    converted_q.push_back(cordic_convert(vec, a, b));
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [11:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 7) return 12'($urandom_range(4095));
    if (sel < 9) return 12'(int'($urandom_range(16)) - 8);
    return $urandom_range(1) ? 12'sd2047 : -12'sd2048;
  endfunction

  function automatic logic signed [11:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return 12'($urandom_range(3215) - 1608);
    // around the quarter-turn fold thresholds
    if (sel < 8) return 12'(int'($urandom_range(6)) - 3 + ($urandom_range(1) ? 804 : -804));
    return 12'($urandom_range(4095));
  endfunction

  task automatic test_rotation_corners(int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    send_item(1'b0, 12'sd2047, 12'sd0);
    send_item(1'b0, -12'sd2048, 12'sd0);
    send_item(1'b0, 12'sd0, 12'sd1000);
    send_item(1'b0, 12'sd2047, 12'sd804);
    send_item(1'b0, 12'sd2047, 12'sd803);
    send_item(1'b0, 12'sd2047, -12'sd804);
    send_item(1'b0, 12'sd2047, -12'sd803);
    send_item(1'b0, -12'sd2048, -12'sd1608);
    send_item(1'b0, 12'sd2047, 12'sd1607);
    // angles outside [-pi, pi), then a small angle just below zero
    send_item(1'b0, 12'sd2047, 12'sd2047);
    send_item(1'b0, -12'sd2048, -12'sd2048);
    send_item(1'b0, 12'sd1, -12'sd1);
    release_input();
  endtask

  task automatic test_vectoring_corners(int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    send_item(1'b1, 12'sd0, 12'sd0);
    send_item(1'b1, 12'sd2047, 12'sd0);
    send_item(1'b1, -12'sd2048, 12'sd0);
    send_item(1'b1, 12'sd0, 12'sd2047);
    send_item(1'b1, 12'sd0, -12'sd2048);
    send_item(1'b1, -12'sd2048, -12'sd2048);
    send_item(1'b1, 12'sd2047, 12'sd2047);
    send_item(1'b1, -12'sd2048, 12'sd2047);
    send_item(1'b1, 12'sd2047, -12'sd2048);
    send_item(1'b1, -12'sd1, 12'sd1);
    send_item(1'b1, -12'sd1, -12'sd1);
    send_item(1'b1, 12'sd1, -12'sd1);
    release_input();
  endtask

  task automatic test_random_mix(int n, int unsigned s_idle, int unsigned r_idle);
    logic vec;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) begin
      vec = 1'($urandom_range(1));
      send_item(vec, pick_operand(), vec ? pick_operand() : pick_angle());
    end
    release_input();
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    cordic_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (converted_q.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d", $time, x_or_magnitude_o,
                 y_or_angle_o);
        mismatches++;
      end else begin
        want = converted_q.pop_front();
        if (x_or_magnitude_o !== want.x_or_mag) begin
          $display("%0t: x_or_magnitude expected %0d got %0d", $time, want.x_or_mag,
                   x_or_magnitude_o);
          mismatches++;
        end
        if (y_or_angle_o !== want.y_or_ang) begin
          $display("%0t: y_or_angle expected %0d got %0d", $time, want.y_or_ang,
                   y_or_angle_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rotation_corners(14, 73);
    test_vectoring_corners(14, 73);
    test_random_mix(133, 14, 73);
    test_random_mix(133, 73, 14);
    test_random_mix(134, 0, 0);
    while (converted_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && converted_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/crv_pkg.sv
rtl/crv_fold.sv
rtl/crv_cell.sv
rtl/crv_gain.sv
rtl/cordic_rotate_vector.sv
tb/cordic_rotate_vector_tb.sv
